// ===== sv/chcb_pkg.sv =====
// Shared types and constants for the canonical Huffman code builder.
package chcb_pkg;

    localparam int MAX_LEN = 16;                  // longest code length
    localparam int LEN_W   = 5;                   // code length field width
    localparam int CNT_W   = 8;                   // per-length count width
    localparam int SYM_W   = 8;                   // symbol width
    localparam int CODE_W  = 16;                  // output code width
    localparam int ACODE_W = CODE_W + 1;          // running code, one guard bit
    localparam int IDX_W   = $clog2(MAX_LEN);     // count table index width
    localparam int KRAFT_W = CNT_W + MAX_LEN;     // weighted count sum width
    localparam int GROUPS  = 4;                   // partial sums in the check tree
    localparam int GROUP_N = MAX_LEN / GROUPS;    // lengths per partial sum

    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_SYMBOL = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_TABLE = 2'd1,
        ERR_BEYOND    = 2'd2
    } err_t;

    // Count table write, issued at transaction acceptance.
    typedef struct packed {
        logic             en;
        logic             restart;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
    } wr_t;

    // Readout result for one symbol.
    typedef struct packed {
        err_t              err;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } res_t;

endpackage

// ===== sv/canonical_huffman_code_builder_unit.sv =====
// Top level of the canonical Huffman code builder (count load, symbol readout).
// Path: a result passes through the stage 1 register and then the output register to m_valid.
// Throughput: one transaction per cycle while the output register is not stalled; a symbol
//   right behind a count transaction waits while the count overflow check finishes in stage 1.
// Reset: synchronous, active low; clears counts, readout pointer and error flag.
//   The count RAM itself is not cleared; per-length nonzero bits cover it.
module canonical_huffman_code_builder_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [chcb_pkg::LEN_W-1:0]   s_code_length,
    input  logic [chcb_pkg::CNT_W-1:0]   s_length_count,
    input  logic [chcb_pkg::SYM_W-1:0]   s_symbol,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [chcb_pkg::SYM_W-1:0]   m_out_symbol,
    output logic [chcb_pkg::CODE_W-1:0]  m_code_bits,
    output logic [chcb_pkg::LEN_W-1:0]   m_code_len,
    output logic [1:0]                   m_error
);

    // Stage 0 (accept cycle): count writes go to the RAM and the check tree
    // leaves; symbol readout runs against the registered RAM data.
    // Stage 1 (p1): check tree finishes; results move to the output register.

    logic                        acc, len_ok, sym_en, block, adv1, p1_has_res;
    logic                        kraft_err, kraft_set;
    logic [chcb_pkg::LEN_W-1:0]  len_m1;
    chcb_pkg::wr_t               wr;
    chcb_pkg::res_t              rd_res;

    logic                        p1_valid_reg, p1_valid_next;
    logic                        p1_chk_reg, p1_chk_next;
    logic                        p1_sym_reg, p1_sym_next;
    logic [chcb_pkg::SYM_W-1:0]  p1_symbol_reg, p1_symbol_next;
    chcb_pkg::res_t              p1_res_reg, p1_res_next;

    logic                        m_valid_reg, m_valid_next;
    logic [chcb_pkg::SYM_W-1:0]  m_symbol_reg, m_symbol_next;
    logic [chcb_pkg::CODE_W-1:0] m_code_reg, m_code_next;
    logic [chcb_pkg::LEN_W-1:0]  m_len_reg, m_len_next;
    chcb_pkg::err_t              m_err_reg, m_err_next;

    // Handshake: p1 frees when the output register can take its result.
    assign adv1    = !m_valid_reg || m_ready;
    // A symbol must see the error flag of a count still in the check stage.
    assign block   = (s_operation == chcb_pkg::OP_SYMBOL) && p1_valid_reg && p1_chk_reg;
    assign s_ready = (!p1_valid_reg || adv1) && !block;
    assign acc     = s_valid && s_ready;

    // Count transactions outside 1..MAX_LEN are dropped without a result.
    assign len_ok = (s_code_length >= chcb_pkg::LEN_W'(1)) &&
                    (s_code_length <= chcb_pkg::LEN_W'(chcb_pkg::MAX_LEN));
    assign len_m1 = s_code_length - chcb_pkg::LEN_W'(1);

    assign wr.en      = acc && (s_operation == chcb_pkg::OP_COUNT) && len_ok;
    assign wr.restart = (s_code_length == chcb_pkg::LEN_W'(1));
    assign wr.idx     = len_m1[chcb_pkg::IDX_W-1:0];
    assign wr.cnt     = s_length_count;
    assign sym_en     = acc && (s_operation == chcb_pkg::OP_SYMBOL);

    // Table error is raised as the failing count leaves the check stage.
    assign kraft_set = p1_valid_reg && p1_chk_reg && kraft_err && adv1;

    chcb_kraft u_kraft (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .over_err (kraft_err)
    );

    chcb_readout u_readout (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .sym_en    (sym_en),
        .kraft_set (kraft_set),
        .res       (rd_res)
    );

    // Stage 1 register
    always_comb begin
        p1_valid_next  = acc ? 1'b1 : (adv1 ? 1'b0 : p1_valid_reg);
        p1_chk_next    = p1_chk_reg;
        p1_sym_next    = p1_sym_reg;
        p1_symbol_next = p1_symbol_reg;
        p1_res_next    = p1_res_reg;
        if (acc) begin
            p1_chk_next    = wr.en;
            p1_sym_next    = sym_en;
            p1_symbol_next = s_symbol;
            p1_res_next    = rd_res;
        end
    end

    assign p1_has_res = p1_valid_reg && (p1_sym_reg || (p1_chk_reg && kraft_err));

    // Output register; a count overflow reports symbol 0 with a zero code.
    always_comb begin
        m_valid_next  = adv1 ? p1_has_res : m_valid_reg;
        m_symbol_next = m_symbol_reg;
        m_code_next   = m_code_reg;
        m_len_next    = m_len_reg;
        m_err_next    = m_err_reg;
        if (adv1 && p1_has_res) begin
            if (p1_sym_reg) begin
                m_symbol_next = p1_symbol_reg;
                m_code_next   = p1_res_reg.code;
                m_len_next    = p1_res_reg.len;
                m_err_next    = p1_res_reg.err;
            end else begin
                m_symbol_next = '0;
                m_code_next   = '0;
                m_len_next    = '0;
                m_err_next    = chcb_pkg::ERR_BAD_TABLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_chk_reg   <= 1'b0;
            p1_sym_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p1_chk_reg   <= p1_chk_next;
            p1_sym_reg   <= p1_sym_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_symbol_reg <= p1_symbol_next;
        p1_res_reg    <= p1_res_next;
        m_symbol_reg  <= m_symbol_next;
        m_code_reg    <= m_code_next;
        m_len_reg     <= m_len_next;
        m_err_reg     <= m_err_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_symbol_reg;
    assign m_code_bits  = m_code_reg;
    assign m_code_len   = m_len_reg;
    assign m_error      = m_err_reg;

    // A good code always has a length in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error == chcb_pkg::ERR_NONE)) |->
            ((m_code_len != '0) &&
             (m_code_len <= chcb_pkg::LEN_W'(chcb_pkg::MAX_LEN))))
        else $error("good code with length out of range");

    // Any error result carries no code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error != chcb_pkg::ERR_NONE)) |->
            ((m_code_bits == '0) && (m_code_len == '0)))
        else $error("error result with nonzero code");

    // Every accepted symbol reaches stage 1 as a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sym_en |=> (p1_valid_reg && p1_sym_reg && !p1_chk_reg))
        else $error("symbol transaction lost before stage 1");

    // No symbol is taken while a count is still in the check stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_chk_reg) |-> !sym_en)
        else $error("symbol accepted ahead of count check");

endmodule

// ===== sv/chcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns old data on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/chcb_kraft.sv =====
// Count overflow check: registered weighted-sum tree over the stored counts.
module chcb_kraft (
    input  logic          aclk,
    input  logic          aresetn,
    input  chcb_pkg::wr_t wr,
    output logic          over_err
);

    logic [chcb_pkg::CNT_W-1:0]   leaf_reg [chcb_pkg::MAX_LEN];
    logic [chcb_pkg::CNT_W-1:0]   leaf_next [chcb_pkg::MAX_LEN];
    logic [chcb_pkg::KRAFT_W-1:0] grp_reg [chcb_pkg::GROUPS];
    logic [chcb_pkg::KRAFT_W-1:0] grp_next [chcb_pkg::GROUPS];
    logic [chcb_pkg::LEN_W-1:0]   chk_len_reg;
    logic [chcb_pkg::CNT_W-1:0]   chk_cnt_reg;
    logic [chcb_pkg::LEN_W-1:0]   wr_len;
    logic [chcb_pkg::KRAFT_W-1:0] wsum;
    logic [chcb_pkg::KRAFT_W-1:0] scaled;
    logic [chcb_pkg::KRAFT_W:0]   total;
    logic                         sum_full;

    localparam logic [chcb_pkg::KRAFT_W-1:0] Full = chcb_pkg::KRAFT_W'(1) << chcb_pkg::MAX_LEN;

    assign wr_len = chcb_pkg::LEN_W'(wr.idx) + chcb_pkg::LEN_W'(1);

    always_comb begin
        for (int k = 0; k < chcb_pkg::MAX_LEN; k++) begin
            leaf_next[k] = wr.restart ? '0 : leaf_reg[k];
        end
        leaf_next[wr.idx] = wr.cnt;
    end

    // stage A: per-group sum of count * 2^(MAX_LEN - length), shorter lengths only
    always_comb begin
        int j;
        for (int g = 0; g < chcb_pkg::GROUPS; g++) begin
            grp_next[g] = '0;
            for (int i = 0; i < chcb_pkg::GROUP_N; i++) begin
                j = g * chcb_pkg::GROUP_N + i + 1;
                if (chcb_pkg::LEN_W'(j) < wr_len) begin
                    grp_next[g] = grp_next[g] +
                        (chcb_pkg::KRAFT_W'(leaf_reg[j-1]) << (chcb_pkg::MAX_LEN - j));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < chcb_pkg::MAX_LEN; k++) begin
                leaf_reg[k] <= '0;
            end
        end else if (wr.en) begin
            leaf_reg <= leaf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            grp_reg     <= grp_next;
            chk_len_reg <= wr_len;
            chk_cnt_reg <= wr.cnt;
        end
    end

    // stage B: free codes exhausted means any nonzero count overflows
    always_comb begin
        wsum = '0;
        for (int g = 0; g < chcb_pkg::GROUPS; g++) begin
            wsum = wsum + grp_reg[g];
        end
    end

    assign scaled   = chcb_pkg::KRAFT_W'(chk_cnt_reg) <<
                      (chcb_pkg::LEN_W'(chcb_pkg::MAX_LEN) - chk_len_reg);
    assign total    = {1'b0, scaled} + {1'b0, wsum};
    assign sum_full = wsum > Full;
    assign over_err = sum_full ? (chk_cnt_reg != '0) : (total > {1'b0, Full});

endmodule

// ===== sv/chcb_readout.sv =====
// Symbol readout: canonical code assignment over the count table RAM.
module chcb_readout (
    input  logic             aclk,
    input  logic             aresetn,
    input  chcb_pkg::wr_t    wr,
    input  logic             sym_en,
    input  logic             kraft_set,
    output chcb_pkg::res_t   res
);

    logic [chcb_pkg::LEN_W-1:0]   alen_reg, alen_next;
    logic [chcb_pkg::CNT_W-1:0]   asg_reg, asg_next;
    logic [chcb_pkg::ACODE_W-1:0] acode_reg, acode_next;
    logic                         terr_reg, terr_next;
    logic [chcb_pkg::MAX_LEN-1:0] nz_reg, nz_next;
    logic                         fwd_hit_reg, fwd_hit_next;
    logic [chcb_pkg::CNT_W-1:0]   fwd_data_reg;

    logic [chcb_pkg::CNT_W-1:0]   ram_q, cnt_raw, cur_cnt, asg_base;
    logic [chcb_pkg::IDX_W-1:0]   raddr, cur_idx;
    logic [chcb_pkg::LEN_W-1:0]   cur_m1, next_m1, nl, new_len, shamt;
    logic [chcb_pkg::ACODE_W-1:0] shifted, limit;
    logic                         in_range, stay, found, beyond, overflow;

    chcb_ram #(
        .WIDTH(chcb_pkg::CNT_W),
        .DEPTH(chcb_pkg::MAX_LEN)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.cnt),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // RAM is read ahead at the next readout length, so its registered data matches alen_reg
    assign next_m1      = alen_next - chcb_pkg::LEN_W'(1);
    assign raddr        = next_m1[chcb_pkg::IDX_W-1:0];
    assign fwd_hit_next = wr.en && (wr.idx == raddr);

    assign cur_m1   = alen_reg - chcb_pkg::LEN_W'(1);
    assign cur_idx  = cur_m1[chcb_pkg::IDX_W-1:0];
    assign in_range = alen_reg <= chcb_pkg::LEN_W'(chcb_pkg::MAX_LEN);
    assign cnt_raw  = fwd_hit_reg ? fwd_data_reg : ram_q;
    assign cur_cnt  = nz_reg[cur_idx] ? cnt_raw : '0;
    assign stay     = in_range && (asg_reg < cur_cnt);
    assign asg_base = stay ? asg_reg : '0;

    // first longer length holding any code
    always_comb begin
        found = 1'b0;
        nl    = '0;
        for (int k = chcb_pkg::MAX_LEN - 1; k >= 0; k--) begin
            if (nz_reg[k] && (chcb_pkg::LEN_W'(k) >= alen_reg)) begin
                found = 1'b1;
                nl    = chcb_pkg::LEN_W'(k + 1);
            end
        end
    end

    assign new_len  = stay ? alen_reg :
                      (found ? nl : chcb_pkg::LEN_W'(chcb_pkg::MAX_LEN + 1));
    assign shamt    = new_len - alen_reg;
    assign shifted  = acode_reg << shamt;
    assign limit    = chcb_pkg::ACODE_W'(1) << new_len;
    assign beyond   = new_len > chcb_pkg::LEN_W'(chcb_pkg::MAX_LEN);
    assign overflow = !beyond && (shifted >= limit);

    always_comb begin
        res.err  = chcb_pkg::ERR_NONE;
        res.code = shifted[chcb_pkg::CODE_W-1:0];
        res.len  = new_len;
        if (terr_reg || overflow) begin
            res.err  = chcb_pkg::ERR_BAD_TABLE;
            res.code = '0;
            res.len  = '0;
        end else if (beyond) begin
            res.err  = chcb_pkg::ERR_BEYOND;
            res.code = '0;
            res.len  = '0;
        end
    end

    always_comb begin
        alen_next  = alen_reg;
        asg_next   = asg_reg;
        acode_next = acode_reg;
        terr_next  = terr_reg || kraft_set;
        nz_next    = nz_reg;
        if (wr.en) begin
            if (wr.restart) begin
                alen_next  = chcb_pkg::LEN_W'(1);
                asg_next   = '0;
                acode_next = '0;
                terr_next  = 1'b0;
                nz_next    = '0;
            end
            nz_next[wr.idx] = (wr.cnt != '0);
        end else if (sym_en && !terr_reg) begin
            alen_next  = new_len;
            acode_next = shifted;
            asg_next   = asg_base;
            if (overflow) begin
                terr_next = 1'b1;
            end else if (!beyond) begin
                acode_next = shifted + chcb_pkg::ACODE_W'(1);
                asg_next   = asg_base + chcb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alen_reg    <= chcb_pkg::LEN_W'(1);
            asg_reg     <= '0;
            acode_reg   <= '0;
            terr_reg    <= 1'b0;
            nz_reg      <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            alen_reg    <= alen_next;
            asg_reg     <= asg_next;
            acode_reg   <= acode_next;
            terr_reg    <= terr_next;
            nz_reg      <= nz_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= wr.cnt;
    end

endmodule

// ===== dv/huffman_code_checker.sv =====
`timescale 1ns / 1ps
// Channel monitor and scoreboard for the canonical Huffman code builder.
module huffman_code_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_operation,
    input  logic [chcb_pkg::LEN_W-1:0]     s_code_length,
    input  logic [chcb_pkg::CNT_W-1:0]     s_length_count,
    input  logic [chcb_pkg::SYM_W-1:0]     s_symbol,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [chcb_pkg::SYM_W-1:0]     m_out_symbol,
    input  logic [chcb_pkg::CODE_W-1:0]    m_code_bits,
    input  logic [chcb_pkg::LEN_W-1:0]     m_code_len,
    input  logic [1:0]                     m_error,
    output int                             fail_count,
    output int                             pending
);

    typedef struct packed {
        logic [chcb_pkg::SYM_W-1:0]  sym;
        logic [chcb_pkg::CODE_W-1:0] code;
        logic [chcb_pkg::LEN_W-1:0]  len;
        chcb_pkg::err_t              err;
    } code_rec_t;

    code_rec_t expected_codes[$];

    // Predicted table and readout pointer
    logic [chcb_pkg::CNT_W-1:0]   len_counts[chcb_pkg::MAX_LEN];
    logic [chcb_pkg::ACODE_W-1:0] next_free;
    int unsigned                  rd_len;
    int unsigned                  rd_in_len;
    int unsigned                  rd_code;
    bit                           bad_table;

    function automatic void clear_table();
        int i;
        for (i = 0; i < chcb_pkg::MAX_LEN; i++) begin
            len_counts[i] = '0;
        end
        next_free = '0;
        rd_len    = 1;
        rd_in_len = 0;
        rd_code   = 0;
        bad_table = 1'b0;
    endfunction

    // Returns 1 when the transaction produces a code record.
    function automatic bit predict_code(input logic op,
                                        input logic [chcb_pkg::LEN_W-1:0] len,
                                        input logic [chcb_pkg::CNT_W-1:0] cnt,
                                        input logic [chcb_pkg::SYM_W-1:0] sym,
                                        output code_rec_t rec);
        int unsigned acc;
        int unsigned full;
        int unsigned i;
        rec = '0;
        if (op == chcb_pkg::OP_COUNT) begin
            if (len < 1 || len > chcb_pkg::MAX_LEN) return 1'b0;
            if (len == 1) clear_table();
            len_counts[len-1] = cnt;
            // first free code at this length, given all shorter counts
            acc = 0;
            for (i = 1; i <= len; i++) begin
                full = 32'd1 << i;
                acc  = acc << 1;
                if (i < len) acc = acc + len_counts[i-1];
                if (acc > full) acc = full;
            end
            next_free = acc[chcb_pkg::ACODE_W-1:0];
            if (cnt > ((32'd1 << len) - next_free)) begin
                bad_table = 1'b1;
                rec.err   = chcb_pkg::ERR_BAD_TABLE;
                return 1'b1;
            end
            return 1'b0;
        end
        rec.sym = sym;
        if (bad_table) begin
            rec.err = chcb_pkg::ERR_BAD_TABLE;
            return 1'b1;
        end
        while (rd_len <= chcb_pkg::MAX_LEN && rd_in_len >= len_counts[rd_len-1]) begin
            rd_code   = (rd_code << 1) & 32'h1FFFF;
            rd_len    = rd_len + 1;
            rd_in_len = 0;
        end
        if (rd_len > chcb_pkg::MAX_LEN) begin
            rec.err = chcb_pkg::ERR_BEYOND;
            return 1'b1;
        end
        if (rd_code >= (32'd1 << rd_len)) begin
            bad_table = 1'b1;
            rec.err   = chcb_pkg::ERR_BAD_TABLE;
            return 1'b1;
        end
        rec.code  = rd_code[chcb_pkg::CODE_W-1:0];
        rec.len   = rd_len[chcb_pkg::LEN_W-1:0];
        rd_code   = (rd_code + 1) & 32'h1FFFF;
        rd_in_len = (rd_in_len + 1) & 32'hFF;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        code_rec_t want;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            clear_table();
            expected_codes.delete();
        end else begin
            // results first, so a code pushed at this edge cannot pair with one popped here
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    $error("unexpected code transaction: out_symbol %0h", m_out_symbol);
                    errs++;
                end else begin
                    want = expected_codes.pop_front();
                    if (m_out_symbol !== want.sym) begin
                        $error("out_symbol: expected %0h, actual %0h", want.sym, m_out_symbol);
                        errs++;
                    end
                    if (m_code_bits !== want.code) begin
                        $error("code_bits: expected %0h, actual %0h", want.code, m_code_bits);
                        errs++;
                    end
                    if (m_code_len !== want.len) begin
                        $error("code_len: expected %0d, actual %0d", want.len, m_code_len);
                        errs++;
                    end
                    if (m_error !== want.err) begin
                        $error("error: expected %0d, actual %0d", want.err, m_error);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (predict_code(s_operation, s_code_length, s_length_count, s_symbol, want))
                    expected_codes.insert(expected_codes.size(), want);
            end
        end
        fail_count <= fail_count + errs;
        pending    <= expected_codes.size();
    end

endmodule

// ===== dv/tb_canonical_huffman_code_builder_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the canonical Huffman code builder: stimulus, receiver stalls, verdict.
module tb_canonical_huffman_code_builder_unit;

    localparam int ITEM_TARGET = 1400;  // non-ignored transactions in the random part
    localparam int STALL_LIMIT = 2000;  // cycles without any handshake before giving up

    logic                          aclk;
    logic                          aresetn        = 1'b0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic                          s_operation    = chcb_pkg::OP_COUNT;
    logic [chcb_pkg::LEN_W-1:0]    s_code_length  = '0;
    logic [chcb_pkg::CNT_W-1:0]    s_length_count = '0;
    logic [chcb_pkg::SYM_W-1:0]    s_symbol       = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [chcb_pkg::SYM_W-1:0]    m_out_symbol;
    logic [chcb_pkg::CODE_W-1:0]   m_code_bits;
    logic [chcb_pkg::LEN_W-1:0]    m_code_len;
    logic [1:0]                    m_error;

    int fail_count;
    int pending;
    int items_sent  = 0;   // transactions the block acts on (ignored counts excluded)
    int burst_left  = 0;   // sender transactions left before the next gap
    int idle_cycles = 0;
    int rdy_mode    = 0;
    int rdy_left    = 0;

    canonical_huffman_code_builder_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_code_length  (s_code_length),
        .s_length_count (s_length_count),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_symbol   (m_out_symbol),
        .m_code_bits    (m_code_bits),
        .m_code_len     (m_code_len),
        .m_error        (m_error)
    );

    huffman_code_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_code_length  (s_code_length),
        .s_length_count (s_length_count),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_symbol   (m_out_symbol),
        .m_code_bits    (m_code_bits),
        .m_code_len     (m_code_len),
        .m_error        (m_error),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: stretches of always-ready, coin-flip, and mostly-stalled behavior.
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(20, 150);
        end else begin
            rdy_left = rdy_left - 1;
        end
        case (rdy_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: any handshake on either channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_canonical_huffman_code_builder_unit NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One transaction. Valid stays up across back-to-back transactions within a burst;
    // it is dropped only when a real gap follows.
    task automatic send_item(input logic op, input logic [chcb_pkg::LEN_W-1:0] len,
                             input logic [chcb_pkg::CNT_W-1:0] cnt,
                             input logic [chcb_pkg::SYM_W-1:0] sym);
        int gap;
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_code_length  <= len;
        s_length_count <= cnt;
        s_symbol       <= sym;
        do @(posedge aclk); while (!s_ready);
        if (!(op == chcb_pkg::OP_COUNT && (len < 1 || len > chcb_pkg::MAX_LEN))) items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // mostly short bursts, now and then a long run with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Count or symbol with don't-care fields randomized, so all field bits toggle.
    task automatic send_count(input int len, input int cnt);
        send_item(chcb_pkg::OP_COUNT, chcb_pkg::LEN_W'(len), chcb_pkg::CNT_W'(cnt),
                  chcb_pkg::SYM_W'($urandom_range(0, 255)));
    endtask

    task automatic send_symbol(input int sym);
        send_item(chcb_pkg::OP_SYMBOL, chcb_pkg::LEN_W'($urandom_range(0, 31)),
                  chcb_pkg::CNT_W'($urandom_range(0, 255)), chcb_pkg::SYM_W'(sym));
    endtask

    // Fully random transaction: any operation, any length including out-of-range ones.
    task automatic send_noise();
        send_item(1'($urandom_range(0, 1)), chcb_pkg::LEN_W'($urandom_range(0, 31)),
                  chcb_pkg::CNT_W'($urandom_range(0, 255)),
                  chcb_pkg::SYM_W'($urandom_range(0, 255)));
    endtask

    // Hold off the sender until every expected code has come back.
    // Waiting on a clock edge first lets the checker's count catch the last accepted transaction.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // One table: counts that mostly fit the code space (optionally one too large,
    // optionally sent out of order), then a readout of its symbols, up to two past the end for small tables.
    // Stray count rewrites during readout exercise the changed-counts path.
    task automatic run_table();
        int cnts[chcb_pkg::MAX_LEN];
        int order[chcb_pkg::MAX_LEN];
        int free_codes;
        int total;
        int cmax;
        int bad_len;
        int nsym;
        int k;
        int j;
        int tmp;
        case ($urandom_range(0, 4))
            0: cmax = 1;
            1: cmax = 2;
            2: cmax = 4;
            3: cmax = 16;
            default: cmax = 255;
        endcase
        bad_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0;
        free_codes = 2;
        total      = 0;
        for (k = 1; k <= chcb_pkg::MAX_LEN; k++) begin
            if (k == bad_len && free_codes < 255)
                cnts[k-1] = $urandom_range(free_codes + 1, 255);
            else
                cnts[k-1] = $urandom_range(0, (free_codes < cmax) ? free_codes : cmax);
            total      = total + cnts[k-1];
            free_codes = (free_codes - cnts[k-1]) * 2;
            if (free_codes < 0) free_codes = 0;
            order[k-1] = k;
        end
        // length 1 always leads (it restarts the table); the rest may be shuffled
        if ($urandom_range(0, 3) == 0) begin
            for (k = chcb_pkg::MAX_LEN - 1; k > 1; k--) begin
                j        = $urandom_range(1, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
        end
        for (k = 0; k < chcb_pkg::MAX_LEN; k++) begin
            if ($urandom_range(0, 39) == 0) send_noise();
            send_count(order[k], cnts[order[k]-1]);
        end
        nsym = (total <= 40) ? total + $urandom_range(0, 2) : $urandom_range(10, 40);
        for (k = 0; k < nsym; k++) begin
            if ($urandom_range(0, 24) == 0)
                send_count($urandom_range(2, chcb_pkg::MAX_LEN), $urandom_range(0, 6));
            if ($urandom_range(0, 29) == 0) send_noise();
            send_symbol($urandom_range(0, 255));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // Count too large at length 1, then a symbol on the bad table.
        send_count(1, 3);
        send_symbol(8'h00);
        // Out-of-range lengths are ignored.
        send_count(0, 255);
        send_count(31, 0);
        send_count(17, 1);
        // Full length-1 table, then one symbol past the end.
        send_count(1, 2);
        send_symbol(8'hFF);
        send_symbol(8'hAA);
        send_symbol(8'h55);
        // Longest length with the largest count, shorter count written afterwards.
        send_count(1, 0);
        send_count(16, 255);
        send_count(2, 1);
        send_symbol(8'h01);
        send_symbol(8'h02);
        // Count raised under readout: codes run out of their length.
        send_count(1, 0);
        send_count(2, 1);
        send_symbol(8'h10);
        send_count(2, 4);
        send_symbol(8'h11);
        send_symbol(8'h12);
        send_symbol(8'h13);
        send_symbol(8'h14);
        send_symbol(8'h15);
        drain_results();

        // --- random part ---
        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            run_table();
            if ($urandom_range(0, 7) == 0) drain_results();
        end

        // let everything land, then wait on to catch stray results
        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_canonical_huffman_code_builder_unit OK");
        else
            $display("tb_canonical_huffman_code_builder_unit NOT OK");
        $finish;
    end

endmodule
